/* hdl/lc3is_pkg.sv */
// ----------------------------------------------------------------------------
// lc3is_pkg: shared types and constants for the LC-3 style step core
// Opcodes, item kinds, condition-code encodings, sign extension helpers
// and the request structs passed between the core and its storage.
// ----------------------------------------------------------------------------
package lc3is_pkg;

    localparam int unsigned WORD_W            = 16;
    localparam int unsigned RF_DEPTH          = 8;
    localparam int unsigned RF_AW             = 3;
    localparam int unsigned CC_W              = 3;
    localparam int unsigned MEM_WORDS_DEFAULT = 65536;

    localparam logic [WORD_W-1:0] START_PC_RESET = 16'h3000;
    localparam logic [7:0]        TRAP_HALT_VEC  = 8'h25;
    localparam logic [RF_AW-1:0]  LINK_REG       = 3'd7;

    // N/Z/P flags
    localparam logic [CC_W-1:0] CC_NEG  = 3'b100;
    localparam logic [CC_W-1:0] CC_ZERO = 3'b010;
    localparam logic [CC_W-1:0] CC_POS  = 3'b001;

    typedef enum logic [3:0] {
        OP_BR   = 4'd0,
        OP_ADD  = 4'd1,
        OP_LD   = 4'd2,
        OP_ST   = 4'd3,
        OP_JSR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDR  = 4'd6,
        OP_STR  = 4'd7,
        OP_RTI  = 4'd8,
        OP_NOT  = 4'd9,
        OP_LDI  = 4'd10,
        OP_STI  = 4'd11,
        OP_JMP  = 4'd12,
        OP_RSV  = 4'd13,
        OP_LEA  = 4'd14,
        OP_TRAP = 4'd15
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_MEM_WR = 2'd0,
        KIND_REG_WR = 2'd1,
        KIND_EXEC   = 2'd2
    } kind_t;

    // word memory request (address wraps to the memory depth inside)
    typedef struct packed {
        logic              en;
        logic              we;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

    // register file write port
    typedef struct packed {
        logic              we;
        logic [RF_AW-1:0]  addr;
        logic [WORD_W-1:0] data;
    } rf_wr_t;

    // register file read request, two ports
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr_a;
        logic [RF_AW-1:0] addr_b;
    } rf_rd_t;

    function automatic logic [CC_W-1:0] cc_of(input logic [WORD_W-1:0] v);
        logic [CC_W-1:0] cc;
        if (v == '0) begin
            cc = CC_ZERO;
        end else if (v[WORD_W-1]) begin
            cc = CC_NEG;
        end else begin
            cc = CC_POS;
        end
        return cc;
    endfunction

    function automatic logic [WORD_W-1:0] sext5(input logic [WORD_W-1:0] ins);
        return {{11{ins[4]}}, ins[4:0]};
    endfunction

    function automatic logic [WORD_W-1:0] sext6(input logic [WORD_W-1:0] ins);
        return {{10{ins[5]}}, ins[5:0]};
    endfunction

    function automatic logic [WORD_W-1:0] sext9(input logic [WORD_W-1:0] ins);
        return {{7{ins[8]}}, ins[8:0]};
    endfunction

    function automatic logic [WORD_W-1:0] sext11(input logic [WORD_W-1:0] ins);
        return {{5{ins[10]}}, ins[10:0]};
    endfunction

endpackage

/* hdl/lc3is_word_mem.sv */
// ----------------------------------------------------------------------------
// lc3is_word_mem: single-port word memory
// One read or one write per cycle, read data registered.
// Addresses wrap to the memory depth (depth is a power of two).
// ----------------------------------------------------------------------------
module lc3is_word_mem #(
    parameter int unsigned MEM_WORDS = lc3is_pkg::MEM_WORDS_DEFAULT
) (
    input  logic                          aclk,
    input  lc3is_pkg::mem_req_t           req,
    output logic [lc3is_pkg::WORD_W-1:0]  rdata
);

    localparam int unsigned AW = $clog2(MEM_WORDS);

    logic [lc3is_pkg::WORD_W-1:0] mem [MEM_WORDS];
    logic [lc3is_pkg::WORD_W-1:0] rdata_reg;
    logic [AW-1:0]                waddr;

    assign waddr = req.addr[AW-1:0];
    assign rdata = rdata_reg;

    // single port: write or registered read
    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[waddr] <= req.wdata;
            end else begin
                rdata_reg <= mem[waddr];
            end
        end
    end

endmodule

/* hdl/lc3is_reg_file.sv */
// ----------------------------------------------------------------------------
// lc3is_reg_file: general register file
// Eight words, two registered read ports, one write port. Per-entry valid
// bits cleared by reset make unwritten registers read as zero.
// ----------------------------------------------------------------------------
module lc3is_reg_file (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lc3is_pkg::rf_rd_t             rd,
    input  lc3is_pkg::rf_wr_t             wr,
    output logic [lc3is_pkg::WORD_W-1:0]  rdata_a,
    output logic [lc3is_pkg::WORD_W-1:0]  rdata_b
);

    logic [lc3is_pkg::WORD_W-1:0]   mem [lc3is_pkg::RF_DEPTH];
    logic [lc3is_pkg::RF_DEPTH-1:0] valid_reg;
    logic [lc3is_pkg::WORD_W-1:0]   data_a_reg;
    logic [lc3is_pkg::WORD_W-1:0]   data_b_reg;
    logic                           vld_a_reg;
    logic                           vld_b_reg;

    // valid bits and read-side valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else begin
            if (wr.we) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                vld_a_reg <= valid_reg[rd.addr_a];
                vld_b_reg <= valid_reg[rd.addr_b];
            end
        end
    end

    // storage and registered read data
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            data_a_reg <= mem[rd.addr_a];
            data_b_reg <= mem[rd.addr_b];
        end
    end

    assign rdata_a = vld_a_reg ? data_a_reg : '0;
    assign rdata_b = vld_b_reg ? data_b_reg : '0;

endmodule

/* hdl/lc3_instruction_step.sv */
// ----------------------------------------------------------------------------
// lc3_instruction_step: LC-3 style instruction step core
// Each beat writes a memory word, writes a register or executes one
// instruction against the word memory and register file; a beat of the unused kind only returns a result.
//
//  channel  | dir | signals                        | content
//  ---------+-----+--------------------------------+---------------------------
//  s_       | in  | tvalid tready tdata[39:0] tuser | address, reg_index,
//           |     |                                | write_data / kind
//  m_       | out | tvalid tready tdata[23:0]      | next_pc, halted, cond_code
//  apb      | in  | psel penable pwrite paddr ...  | start_pc at byte addr 0
//
// Memory and register writes commit from ST_SIMPLE; execute steps through
// fetch, decode and execute, then load (LD/LDR), indirect and load (LDI) or
// indirect (STI), bounded by the single word-memory port and its registered read.
// The next beat is accepted in the cycle the previous result is committed.
// A stalled m_ side holds the core in its final step; the result register
// lets one finished result wait while the next beat is taken.
// Reset (aresetn, synchronous) loads PC and start_pc with 16'h3000, clears CC and the
// register file; word memory holds no reset value.
// ----------------------------------------------------------------------------
module lc3_instruction_step #(
    parameter int unsigned MEM_WORDS = lc3is_pkg::MEM_WORDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[15:0], reg_index[18:16], write_data[34:19]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // next_pc[15:0], halted[16], cond_code[19:17]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIMPLE,
        ST_FETCH,
        ST_DECODE,
        ST_EXEC,
        ST_IND,
        ST_LOAD
    } state_t;

    localparam int unsigned W = lc3is_pkg::WORD_W;

    state_t                      state_reg, state_next;
    logic [W-1:0]                pc_reg, pc_next;
    logic [lc3is_pkg::CC_W-1:0]  cc_reg, cc_next;
    logic [W-1:0]                start_pc_reg, start_pc_next;
    logic                        m_valid_reg, m_valid_next;
    logic [W-1:0]                res_pc_reg, res_pc_next;
    logic                        res_halt_reg, res_halt_next;
    logic [lc3is_pkg::CC_W-1:0]  res_cc_reg, res_cc_next;

    // item and instruction payload
    logic [1:0]                  kind_reg;
    logic [W-1:0]                addr_reg;
    logic [lc3is_pkg::RF_AW-1:0] ri_reg;
    logic [W-1:0]                wdata_reg;
    logic [W-1:0]                ins_reg;
    logic [W-1:0]                pc_inc_reg;

    lc3is_pkg::mem_req_t         mem_req;
    lc3is_pkg::rf_rd_t           rf_rd;
    lc3is_pkg::rf_wr_t           rf_wr;
    logic [W-1:0]                mem_rdata;
    logic [W-1:0]                rf_a;
    logic [W-1:0]                rf_b;

    logic                        s_accept;
    logic                        out_free;
    logic                        commit;
    logic                        cfg_wr;

    // decode of the fetched word (valid in ST_DECODE)
    lc3is_pkg::opcode_t          fetch_op;
    logic                        fetch_is_store;

    // execute-step values
    lc3is_pkg::opcode_t          op;
    logic [lc3is_pkg::RF_AW-1:0] dr;
    logic [W-1:0]                bval;
    logic [W-1:0]                pc_off9;
    logic [W-1:0]                base_off6;
    logic [W-1:0]                alu_res;
    logic [W-1:0]                br_target;
    logic                        ins_zero;
    logic                        exec_cont;

    // ------------------------------------------------------------------
    // storage
    lc3is_word_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_word_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    lc3is_reg_file u_reg_file (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rf_rd),
        .wr      (rf_wr),
        .rdata_a (rf_a),
        .rdata_b (rf_b)
    );

    // ------------------------------------------------------------------
    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'h0000, start_pc_reg} : 32'h0;

    // ------------------------------------------------------------------
    // handshakes
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, res_cc_reg, res_halt_reg, res_pc_reg};

    // ------------------------------------------------------------------
    // fetched word decode: pick register read addresses
    assign fetch_op       = lc3is_pkg::opcode_t'(mem_rdata[15:12]);
    assign fetch_is_store = (fetch_op == lc3is_pkg::OP_ST) ||
                            (fetch_op == lc3is_pkg::OP_STR) ||
                            (fetch_op == lc3is_pkg::OP_STI);

    always_comb begin
        rf_rd.en     = (state_reg == ST_DECODE);
        rf_rd.addr_a = mem_rdata[8:6];
        rf_rd.addr_b = fetch_is_store ? mem_rdata[11:9] : mem_rdata[2:0];
    end

    // ------------------------------------------------------------------
    // execute datapath
    assign op        = lc3is_pkg::opcode_t'(ins_reg[15:12]);
    assign dr        = ins_reg[11:9];
    assign bval      = ins_reg[5] ? lc3is_pkg::sext5(ins_reg) : rf_b;
    assign pc_off9   = pc_inc_reg + lc3is_pkg::sext9(ins_reg);
    assign base_off6 = rf_a + lc3is_pkg::sext6(ins_reg);
    assign ins_zero  = (ins_reg == '0);
    assign exec_cont = (op == lc3is_pkg::OP_LD) || (op == lc3is_pkg::OP_LDR) ||
                       (op == lc3is_pkg::OP_LDI) || (op == lc3is_pkg::OP_STI);

    always_comb begin
        case (op)
            lc3is_pkg::OP_ADD: alu_res = rf_a + bval;
            lc3is_pkg::OP_AND: alu_res = rf_a & bval;
            default:           alu_res = ~rf_a;
        endcase
    end

    // PC for control transfers; everything else falls through
    always_comb begin
        unique case (op) inside
            lc3is_pkg::OP_BR:   br_target = ((dr & cc_reg) != '0) ? pc_off9 : pc_inc_reg;
            lc3is_pkg::OP_JSR:  br_target = pc_inc_reg + lc3is_pkg::sext11(ins_reg);
            lc3is_pkg::OP_JMP:  br_target = rf_a;
            lc3is_pkg::OP_TRAP: br_target = (ins_reg[7:0] == lc3is_pkg::TRAP_HALT_VEC) ?
                                            '0 : pc_inc_reg;
            default:            br_target = pc_inc_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: next state, storage requests, result
    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        cc_next       = cc_reg;
        start_pc_next = start_pc_reg;
        res_pc_next   = res_pc_reg;
        res_halt_next = res_halt_reg;
        res_cc_next   = res_cc_reg;
        commit        = 1'b0;
        mem_req       = '0;
        rf_wr         = '0;

        unique case (state_reg)
            ST_IDLE: begin
            end

            // memory or register write, or an unused kind
            ST_SIMPLE: begin
                commit = out_free;
                if (commit) begin
                    case (kind_reg)
                        lc3is_pkg::KIND_MEM_WR: begin
                            mem_req.en    = 1'b1;
                            mem_req.we    = 1'b1;
                            mem_req.addr  = addr_reg;
                            mem_req.wdata = wdata_reg;
                        end
                        lc3is_pkg::KIND_REG_WR: begin
                            rf_wr.we   = 1'b1;
                            rf_wr.addr = ri_reg;
                            rf_wr.data = wdata_reg;
                        end
                        default: begin
                        end
                    endcase
                    res_pc_next   = pc_reg;
                    res_halt_next = 1'b0;
                    res_cc_next   = cc_reg;
                end
            end

            ST_FETCH: begin
                mem_req.en   = 1'b1;
                mem_req.addr = pc_reg;
                state_next   = ST_DECODE;
            end

            ST_DECODE: begin
                state_next = ST_EXEC;
            end

            ST_EXEC: begin
                if (exec_cont) begin
                    // first data access; PC settles to the increment
                    mem_req.en   = 1'b1;
                    mem_req.addr = (op == lc3is_pkg::OP_LDR) ? base_off6 : pc_off9;
                    pc_next      = pc_inc_reg;
                    state_next   = (op == lc3is_pkg::OP_LD || op == lc3is_pkg::OP_LDR) ?
                                   ST_LOAD : ST_IND;
                end else begin
                    commit = out_free;
                    if (commit) begin
                        pc_next = br_target;
                        unique case (op) inside
                            lc3is_pkg::OP_ADD, lc3is_pkg::OP_AND, lc3is_pkg::OP_NOT: begin
                                rf_wr.we   = 1'b1;
                                rf_wr.addr = dr;
                                rf_wr.data = alu_res;
                                cc_next    = lc3is_pkg::cc_of(alu_res);
                            end
                            lc3is_pkg::OP_ST, lc3is_pkg::OP_STR: begin
                                mem_req.en    = 1'b1;
                                mem_req.we    = 1'b1;
                                mem_req.addr  = (op == lc3is_pkg::OP_STR) ?
                                                base_off6 : pc_off9;
                                mem_req.wdata = rf_b;
                            end
                            lc3is_pkg::OP_JSR: begin
                                rf_wr.we   = 1'b1;
                                rf_wr.addr = lc3is_pkg::LINK_REG;
                                rf_wr.data = pc_inc_reg;
                            end
                            lc3is_pkg::OP_LEA: begin
                                rf_wr.we   = 1'b1;
                                rf_wr.addr = dr;
                                rf_wr.data = pc_off9;
                            end
                            default: begin
                            end
                        endcase
                        res_pc_next   = ins_zero ? '0 : br_target;
                        res_halt_next = ins_zero;
                        res_cc_next   = ((op == lc3is_pkg::OP_ADD) ||
                                         (op == lc3is_pkg::OP_AND) ||
                                         (op == lc3is_pkg::OP_NOT)) ?
                                        lc3is_pkg::cc_of(alu_res) : cc_reg;
                    end
                end
            end

            // pointer in hand: LDI reads through it, STI writes through it
            ST_IND: begin
                if (op == lc3is_pkg::OP_LDI) begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = mem_rdata;
                    state_next   = ST_LOAD;
                end else begin
                    commit = out_free;
                    if (commit) begin
                        mem_req.en    = 1'b1;
                        mem_req.we    = 1'b1;
                        mem_req.addr  = mem_rdata;
                        mem_req.wdata = rf_b;
                        res_pc_next   = pc_reg;
                        res_halt_next = 1'b0;
                        res_cc_next   = cc_reg;
                    end
                end
            end

            ST_LOAD: begin
                commit = out_free;
                if (commit) begin
                    rf_wr.we      = 1'b1;
                    rf_wr.addr    = dr;
                    rf_wr.data    = mem_rdata;
                    cc_next       = lc3is_pkg::cc_of(mem_rdata);
                    res_pc_next   = pc_reg;
                    res_halt_next = 1'b0;
                    res_cc_next   = lc3is_pkg::cc_of(mem_rdata);
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // finished item leaves; next beat may enter in the same cycle
        if (commit) begin
            state_next = ST_IDLE;
        end
        if (s_accept) begin
            state_next = (lc3is_pkg::kind_t'(s_tuser) == lc3is_pkg::KIND_EXEC) ?
                         ST_FETCH : ST_SIMPLE;
        end

        // result register
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        // start_pc write also reloads the PC
        if (cfg_wr) begin
            start_pc_next = pwdata[W-1:0];
            pc_next       = pwdata[W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_pc_reg <= lc3is_pkg::START_PC_RESET;
            pc_reg       <= lc3is_pkg::START_PC_RESET;
            cc_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            start_pc_reg <= start_pc_next;
            pc_reg       <= pc_next;
            cc_reg       <= cc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_pc_reg   <= res_pc_next;
        res_halt_reg <= res_halt_next;
        res_cc_reg   <= res_cc_next;
        if (s_accept) begin
            kind_reg  <= s_tuser;
            addr_reg  <= s_tdata[15:0];
            ri_reg    <= s_tdata[18:16];
            wdata_reg <= s_tdata[34:19];
        end
        if (state_reg == ST_DECODE) begin
            ins_reg    <= mem_rdata;
            pc_inc_reg <= pc_reg + 16'd1;
        end
    end

endmodule

/* tb/sv/lc3_instruction_step_tb.sv */
// ----------------------------------------------------------------------------
// lc3_instruction_step_tb: self-checking bench for the LC-3 style step core
// Beats that load memory, set registers and execute instructions are
// generated against a shadow copy of the architectural state. Operand
// and fetch words are always written before they are read. Every result
// beat is checked field by field against the shadow's prediction. Both
// stream sides idle at random, and start_pc is changed between phases.
// ----------------------------------------------------------------------------
module lc3_instruction_step_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 11;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 32;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 310;

    localparam logic [2:0] REG_START_PC = 3'd0;
    // kind code with no function, ignored by the core
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // at least one instruction per opcode, plus a zero word, with edge offsets
    localparam int DIR_LEN = 19;
    localparam logic [15:0] DIR_PROG [DIR_LEN] = '{
        {lc3is_pkg::OP_ADD,  3'd3, 3'd1, 3'b000, 3'd2},
        {lc3is_pkg::OP_ADD,  3'd4, 3'd1, 1'b1, 5'd1},
        {lc3is_pkg::OP_AND,  3'd5, 3'd1, 1'b1, 5'h10},
        {lc3is_pkg::OP_NOT,  3'd6, 3'd2, 6'h3F},
        {lc3is_pkg::OP_BR,   3'b100, 9'h0FF},
        16'h0000,
        {lc3is_pkg::OP_LD,   3'd0, 9'h100},
        {lc3is_pkg::OP_LDI,  3'd1, 9'h001},
        {lc3is_pkg::OP_LDR,  3'd2, 3'd7, 6'h20},
        {lc3is_pkg::OP_LEA,  3'd3, 9'h1FF},
        {lc3is_pkg::OP_ST,   3'd6, 9'h002},
        {lc3is_pkg::OP_STI,  3'd1, 9'h1FE},
        {lc3is_pkg::OP_STR,  3'd4, 3'd3, 6'h1F},
        {lc3is_pkg::OP_RTI,  12'h000},
        {lc3is_pkg::OP_RSV,  12'hFFF},
        {lc3is_pkg::OP_JSR,  1'b1, 11'h400},
        {lc3is_pkg::OP_JMP,  3'b000, 3'd7, 6'h00},
        {lc3is_pkg::OP_TRAP, 4'h0, 8'h23},
        {lc3is_pkg::OP_TRAP, 4'h0, lc3is_pkg::TRAP_HALT_VEC}
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [2:0]  ridx;
        logic [15:0] wdata;
    } step_item_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        halted;
        logic [2:0]  cc;
    } step_result_t;

    typedef struct packed {
        step_item_t   item;
        step_result_t res;
    } beat_t;

    // DUT ports
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // address[15:0], reg_index[18:16], write_data[34:19]
    logic [1:0]  s_tuser  = '0;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;          // next_pc[15:0], halted[16], cond_code[19:17]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow architectural state
    logic [15:0] core_gpr [8];
    logic [15:0] core_pc;
    logic [2:0]  core_cc;
    logic [15:0] core_mem [65536];
    bit          mem_valid [65536];

    beat_t        queued_beats [$];
    step_result_t pending_results [$];
    beat_t        s_beat;
    logic         s_taken = 1'b0;
    int           src_gap = 0;
    int           sink_hold = 0;
    int unsigned  r_src;
    int unsigned  r_sink;
    int           gen_count = 0;
    int           mismatches = 0;
    int           cycle_count;
    step_result_t want;

    lc3_instruction_step DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
        $display("[%0t] %s: got %h, want %h", $time, what, got, exp_val);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // shadow core
    // ------------------------------------------------------------------
    function automatic logic [15:0] sign_ext(input logic [15:0] v, input int bits);
        logic [15:0] m;
        logic [15:0] f;
        m = 16'd1 << (bits - 1);
        f = v & ((16'd1 << bits) - 16'd1);
        return (f ^ m) - m;
    endfunction

    function automatic void mem_store(input logic [15:0] a, input logic [15:0] d);
        core_mem[a]  = d;
        mem_valid[a] = 1'b1;
    endfunction

    function automatic void write_dest(input logic [2:0] dr, input logic [15:0] v);
        core_gpr[dr] = v;
        if (v == 16'd0) begin
            core_cc = lc3is_pkg::CC_ZERO;
        end else if (v[15]) begin
            core_cc = lc3is_pkg::CC_NEG;
        end else begin
            core_cc = lc3is_pkg::CC_POS;
        end
    endfunction

    function automatic step_result_t step_core(input step_item_t it);
        step_result_t r;
        logic [15:0]  ins;
        logic [15:0]  b;
        logic [15:0]  p;
        logic [2:0]   dr;
        logic [2:0]   sr1;
        logic         halt;
        halt = 1'b0;
        if (it.kind == lc3is_pkg::KIND_MEM_WR) begin
            mem_store(it.addr, it.wdata);
        end else if (it.kind == lc3is_pkg::KIND_REG_WR) begin
            core_gpr[it.ridx] = it.wdata;
        end else if (it.kind == lc3is_pkg::KIND_EXEC) begin
            ins     = core_mem[core_pc];
            dr      = ins[11:9];
            sr1     = ins[8:6];
            core_pc = core_pc + 16'd1;
            b       = ins[5] ? sign_ext(ins, 5) : core_gpr[ins[2:0]];
            case (lc3is_pkg::opcode_t'(ins[15:12]))
                lc3is_pkg::OP_BR: begin
                    if ((dr & core_cc) != 3'd0) core_pc = core_pc + sign_ext(ins, 9);
                end
                lc3is_pkg::OP_ADD: write_dest(dr, core_gpr[sr1] + b);
                lc3is_pkg::OP_AND: write_dest(dr, core_gpr[sr1] & b);
                lc3is_pkg::OP_NOT: write_dest(dr, ~core_gpr[sr1]);
                lc3is_pkg::OP_LD: begin
                    p = core_pc + sign_ext(ins, 9);
                    write_dest(dr, core_mem[p]);
                end
                lc3is_pkg::OP_ST: begin
                    p = core_pc + sign_ext(ins, 9);
                    mem_store(p, core_gpr[dr]);
                end
                lc3is_pkg::OP_LDR: begin
                    p = core_gpr[sr1] + sign_ext(ins, 6);
                    write_dest(dr, core_mem[p]);
                end
                lc3is_pkg::OP_STR: begin
                    p = core_gpr[sr1] + sign_ext(ins, 6);
                    mem_store(p, core_gpr[dr]);
                end
                lc3is_pkg::OP_LDI: begin
                    p = core_pc + sign_ext(ins, 9);
                    p = core_mem[p];
                    write_dest(dr, core_mem[p]);
                end
                lc3is_pkg::OP_STI: begin
                    p = core_pc + sign_ext(ins, 9);
                    p = core_mem[p];
                    mem_store(p, core_gpr[dr]);
                end
                lc3is_pkg::OP_JSR: begin
                    core_gpr[lc3is_pkg::LINK_REG] = core_pc;
                    core_pc = core_pc + sign_ext(ins, 11);
                end
                lc3is_pkg::OP_JMP: core_pc = core_gpr[sr1];
                lc3is_pkg::OP_LEA: core_gpr[dr] = core_pc + sign_ext(ins, 9);
                lc3is_pkg::OP_TRAP: begin
                    if (ins[7:0] == lc3is_pkg::TRAP_HALT_VEC) core_pc = 16'd0;
                end
                default: ;
            endcase
            halt = (ins == 16'd0);
        end
        r.next_pc = halt ? 16'd0 : core_pc;
        r.halted  = halt;
        r.cc      = core_cc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders: each beat is predicted as it is queued
    // ------------------------------------------------------------------
    function automatic void queue_beat(input step_item_t it);
        beat_t bt;
        bt.item = it;
        bt.res  = step_core(it);
        queued_beats.push_back(bt);
        if (it.kind != KIND_UNUSED) gen_count++;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_instr();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return 16'h0000;
        end else if (r < 8) begin
            return {lc3is_pkg::OP_TRAP, 4'h0, lc3is_pkg::TRAP_HALT_VEC};
        end else if (r < 16) begin
            // short branches keep a run near its own code
            return {lc3is_pkg::OP_BR, 3'($urandom), 9'($urandom_range(0, 15)) - 9'd4};
        end
        return 16'($urandom);
    endfunction

    function automatic void put_word(input logic [15:0] a, input logic [15:0] d);
        queue_beat(step_item_t'{lc3is_pkg::KIND_MEM_WR, a, 3'($urandom), d});
    endfunction

    function automatic void need_word(input logic [15:0] a);
        if (!mem_valid[a]) put_word(a, rand_word());
    endfunction

    // make sure the fetch and every operand read hit written words, then execute
    function automatic void run_exec();
        logic [15:0] ins;
        logic [15:0] npc;
        logic [15:0] p;
        if (!mem_valid[core_pc]) put_word(core_pc, rand_instr());
        ins = core_mem[core_pc];
        npc = core_pc + 16'd1;
        case (lc3is_pkg::opcode_t'(ins[15:12]))
            lc3is_pkg::OP_LD:  need_word(npc + sign_ext(ins, 9));
            lc3is_pkg::OP_LDR: need_word(core_gpr[ins[8:6]] + sign_ext(ins, 6));
            lc3is_pkg::OP_STI: need_word(npc + sign_ext(ins, 9));
            lc3is_pkg::OP_LDI: begin
                p = npc + sign_ext(ins, 9);
                need_word(p);
                need_word(core_mem[p]);
            end
            default: ;
        endcase
        queue_beat(step_item_t'{lc3is_pkg::KIND_EXEC, 16'($urandom), 3'($urandom),
                                16'($urandom)});
    endfunction

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [2:0] a, input logic [31:0] d);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read(input logic [2:0] a, output logic [31:0] d);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        d = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (queued_beats.size() != 0 || s_tvalid || pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------
    // input driver: one beat in flight, random gaps between beats
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (queued_beats.size() != 0) begin
                s_beat = queued_beats.pop_front();
                s_tdata  <= {5'd0, s_beat.item.wdata, s_beat.item.ridx, s_beat.item.addr};
                s_tuser  <= s_beat.item.kind;
                s_tvalid <= 1'b1;
                r_src = $urandom_range(0, 99);
                if (r_src < 60) begin
                    src_gap = 0;
                end else if (r_src < 93) begin
                    src_gap = $urandom_range(1, 3);
                end else begin
                    src_gap = $urandom_range(8, 30);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure: ready runs, short stalls, a few long ones
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
        end else begin
            r_sink = $urandom_range(0, 99);
            if (r_sink < 55) begin
                m_tready <= 1'b1;
                sink_hold = $urandom_range(0, 24);
            end else if (r_sink < 92) begin
                m_tready <= 1'b0;
                sink_hold = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                sink_hold = $urandom_range(8, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: record accepted beats, check result beats in order
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) pending_results.push_back(s_beat.res);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("result beat with nothing pending", m_tdata[15:0], 16'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[15:0] !== want.next_pc) begin
                        note_mismatch("next_pc", m_tdata[15:0], want.next_pc);
                    end
                    if (m_tdata[16] !== want.halted) begin
                        note_mismatch("halted", {15'd0, m_tdata[16]}, {15'd0, want.halted});
                    end
                    if (m_tdata[19:17] !== want.cc) begin
                        note_mismatch("cond_code", {13'd0, m_tdata[19:17]}, {13'd0, want.cc});
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("lc3_instruction_step: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed beats, then random phases per start_pc
    // ------------------------------------------------------------------
    initial begin
        int          phase;
        int          goal;
        int          k;
        int          i;
        int          j;
        int unsigned r;
        logic [15:0] base;
        logic [15:0] cfg_val;
        logic [31:0] rd;
        logic [8:0]  o9;
        logic [5:0]  o6;
        logic [2:0]  ra;
        logic [2:0]  rb;
        logic [2:0]  rc;

        for (j = 0; j < 8; j++) core_gpr[j] = 16'd0;
        core_pc = lc3is_pkg::START_PC_RESET;
        core_cc = 3'd0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 0) begin
                // register and memory extremes, the ignored kind, then at least one of each op
                queue_beat(step_item_t'{lc3is_pkg::KIND_REG_WR, 16'hFFFF, 3'd0, 16'h0000});
                queue_beat(step_item_t'{lc3is_pkg::KIND_REG_WR, 16'h0000, 3'd1, 16'hFFFF});
                queue_beat(step_item_t'{lc3is_pkg::KIND_REG_WR, 16'h1234, 3'd2, 16'h7FFF});
                queue_beat(step_item_t'{lc3is_pkg::KIND_REG_WR, 16'h0000, 3'd7, 16'h8000});
                queue_beat(step_item_t'{KIND_UNUSED, 16'hFFFF, 3'd7, 16'hFFFF});
                put_word(16'hFFFF, 16'hFFFF);
                put_word(16'h0000, 16'h0000);
                for (j = 0; j < DIR_LEN; j++) begin
                    put_word(core_pc, DIR_PROG[j]);
                    run_exec();
                end
                // after the halt trap, fetch from address zero
                run_exec();
            end else begin
                wait_idle();
                case (phase)
                    1: cfg_val = 16'h0000;
                    2: cfg_val = 16'hFFFF;
                    default: cfg_val = 16'($urandom);
                endcase
                cfg_write(REG_START_PC, {16'd0, cfg_val});
                core_pc = cfg_val;
                cfg_read(REG_START_PC, rd);
                if (rd[15:0] !== cfg_val) note_mismatch("start_pc readback", rd[15:0], cfg_val);
            end

            goal = gen_count + PHASE_ITEMS;
            while (gen_count < goal) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    // lay down a short program at PC, then step through it
                    k    = $urandom_range(2, 8);
                    base = core_pc;
                    i    = 0;
                    while (i < k) begin
                        if (i + 1 < k && $urandom_range(0, 4) == 0) begin
                            // store followed by a load of the same word
                            ra = 3'($urandom);
                            rb = 3'($urandom);
                            rc = 3'($urandom);
                            if ($urandom_range(0, 1) == 0) begin
                                o6 = 6'($urandom);
                                put_word(16'(base + i), {lc3is_pkg::OP_STR, ra, rb, o6});
                                put_word(16'(base + i + 1), {lc3is_pkg::OP_LDR, rc, rb, o6});
                            end else begin
                                o9 = 9'($urandom);
                                put_word(16'(base + i), {lc3is_pkg::OP_ST, ra, o9});
                                put_word(16'(base + i + 1),
                                         {lc3is_pkg::OP_LD, rc, 9'(o9 - 9'd1)});
                            end
                            i += 2;
                        end else begin
                            put_word(16'(base + i), rand_instr());
                            i++;
                        end
                    end
                    repeat (k) run_exec();
                end else if (r < 70) begin
                    run_exec();
                end else if (r < 82) begin
                    queue_beat(step_item_t'{lc3is_pkg::KIND_REG_WR, 16'($urandom),
                                            3'($urandom), rand_word()});
                end else if (r < 90) begin
                    queue_beat(step_item_t'{lc3is_pkg::KIND_MEM_WR, 16'($urandom),
                                            3'($urandom), rand_word()});
                end else if (r < 96) begin
                    // rewrite code just ahead of PC
                    queue_beat(step_item_t'{lc3is_pkg::KIND_MEM_WR,
                                            core_pc + 16'($urandom_range(0, 7)),
                                            3'($urandom), rand_instr()});
                end else begin
                    queue_beat(step_item_t'{KIND_UNUSED, 16'($urandom), 3'($urandom),
                                            16'($urandom)});
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("lc3_instruction_step: match");
        end else begin
            $display("lc3_instruction_step: mismatch");
        end
        $finish;
    end

endmodule
